// ===== design/rrcs_pkg.sv =====
// rrcs_pkg: shared types and constants for range_rotate_count_store.
// Operation codes, engine states, result record and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package rrcs_pkg;

    localparam int DEF_ARRAY_DEPTH = 1024;
    localparam int DEF_VALUE_BITS  = 16;

    localparam int LEN_BITS   = 11;
    localparam int IDX_BITS   = 10;
    localparam int KEY_BITS   = 16;
    localparam int COUNT_BITS = 11;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ROTATE = 2'd1,
        OP_COUNT  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT_HI,
        ST_ROT,
        ST_CNT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] match_count;
        logic                  status;
    } res_t;

endpackage

// ===== design/rrcs_engine.sv =====
// rrcs_engine: element memory plus the sequencer that runs load, rotate and count.
// Registered-read memory; rotate walks the range read-modify-write, count walks it read-only.
// Depends on rrcs_pkg.
`timescale 1ns / 1ps

module rrcs_engine #(
    parameter int ARRAY_DEPTH = rrcs_pkg::DEF_ARRAY_DEPTH,
    parameter int VALUE_BITS  = rrcs_pkg::DEF_VALUE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     operation,
    input  logic [rrcs_pkg::IDX_BITS-1:0]  left_index,
    input  logic [rrcs_pkg::IDX_BITS-1:0]  right_index,
    input  logic [rrcs_pkg::KEY_BITS-1:0]  key_value,
    input  logic [rrcs_pkg::KEY_BITS-1:0]  element_value,
    input  logic [rrcs_pkg::LEN_BITS-1:0]  array_length,
    input  logic                           res_free,
    output logic                           res_valid,
    output rrcs_pkg::res_t                 res
);
    import rrcs_pkg::*;

    localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;

    logic [VALUE_BITS-1:0] mem [ARRAY_DEPTH];
    logic [VALUE_BITS-1:0] rdata_reg;
    logic                  mem_we;
    logic [AW-1:0]         waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [AW-1:0]         raddr;

    state_t state_reg, state_next;

    logic [AW-1:0]         ptr_reg, hi_reg;
    logic [VALUE_BITS-1:0] key_reg, carry_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  status_reg;

    logic [IDX_BITS-1:0] lo_in, hi_in;
    logic                err;
    logic                accept;
    logic                last;
    op_t                 op;

    function automatic logic out_of_range(input logic [IDX_BITS-1:0] idx,
                                          input logic [LEN_BITS-1:0] len);
        out_of_range = ({1'b0, idx} >= len) || (32'(idx) >= 32'(ARRAY_DEPTH));
    endfunction

    assign op     = op_t'(operation);
    assign lo_in  = (left_index > right_index) ? right_index : left_index;
    assign hi_in  = (left_index > right_index) ? left_index : right_index;
    assign accept = in_valid && in_ready;
    assign last   = (ptr_reg == hi_reg);

    always_comb
    begin
        unique case (op) inside
            OP_LOAD:   err = out_of_range(left_index, array_length);
            OP_ROTATE,
            OP_COUNT:  err = out_of_range(hi_in, array_length);
            default:   err = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (err)
                        state_next = ST_RESULT;
                    else if (op == OP_ROTATE)
                        state_next = ST_ROT_HI;
                    else if (op == OP_COUNT)
                        state_next = ST_CNT;
                    else
                        state_next = ST_RESULT;
                end
            end
            ST_ROT_HI: state_next = ST_ROT;
            ST_ROT:    if (last) state_next = ST_RESULT;
            ST_CNT:    if (last) state_next = ST_RESULT;
            ST_RESULT: if (res_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        waddr     = ptr_reg;
        wdata     = carry_reg;
        raddr     = ptr_reg + AW'(1);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                raddr    = (op == OP_ROTATE) ? AW'(hi_in) : AW'(lo_in);
                waddr    = AW'(left_index);
                wdata    = VALUE_BITS'(element_value);
                mem_we   = in_valid && (op == OP_LOAD) && !err;
            end
            ST_ROT_HI: raddr = ptr_reg;
            ST_ROT:    mem_we = 1'b1;
            ST_CNT:    mem_we = 1'b0;
            ST_RESULT: res_valid = res_free;
            default:   mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hi_reg     <= AW'(hi_in);
            ptr_reg    <= AW'(lo_in);
            key_reg    <= VALUE_BITS'(key_value);
            cnt_reg    <= '0;
            status_reg <= err;
        end
        else if (state_reg == ST_ROT_HI)
        begin
            carry_reg <= rdata_reg;
        end
        else if (state_reg == ST_ROT)
        begin
            carry_reg <= rdata_reg;
            ptr_reg   <= ptr_reg + AW'(1);
        end
        else if (state_reg == ST_CNT)
        begin
            if (rdata_reg == key_reg)
                cnt_reg <= cnt_reg + COUNT_BITS'(1);
            ptr_reg <= ptr_reg + AW'(1);
        end
    end

    assign res.match_count = cnt_reg;
    assign res.status      = status_reg;

endmodule

// ===== design/range_rotate_count_store_top.sv =====
// range_rotate_count_store_top: array store with load, range rotate and range count.
// Holds the length register and the output register; instantiates rrcs_engine.
// Depends on rrcs_pkg, rrcs_engine.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): operation, left_index, right_index,
//   key_value, element_value. Each transfer yields exactly one result transfer
//   on the output channel (out_valid/out_ready): match_count, status.
//   cfg_we/cfg_wdata write array_length; write it only while idle.
// Operation flow
//   Load, unused operation or out-of-range index go straight to the result
//   state. Count and rotate walk the range one element at a time, reading
//   through the read port of the element memory; rotate also writes each
//   element back through the write port. One operation runs at a time, so a
//   new input is taken only after the previous result has left the engine.
// Reset
//   Clears control state and sets array_length to 1024. Element contents are
//   undefined until loaded; no clearing pass runs.
// Stall
//   A finished result waits in the output register; the next input transfer
//   is taken meanwhile, and its result holds in the engine until the output
//   register frees.
module range_rotate_count_store_top #(
    parameter int ARRAY_DEPTH = rrcs_pkg::DEF_ARRAY_DEPTH,
    parameter int VALUE_BITS  = rrcs_pkg::DEF_VALUE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rrcs_pkg::LEN_BITS-1:0]   cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      operation,
    input  logic [rrcs_pkg::IDX_BITS-1:0]   left_index,
    input  logic [rrcs_pkg::IDX_BITS-1:0]   right_index,
    input  logic [rrcs_pkg::KEY_BITS-1:0]   key_value,
    input  logic [rrcs_pkg::KEY_BITS-1:0]   element_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rrcs_pkg::COUNT_BITS-1:0] match_count,
    output logic                            status
);
    import rrcs_pkg::*;

    logic [LEN_BITS-1:0] array_length_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;
    logic                res_free;
    logic                res_valid;
    res_t                res;

    assign res_free = !out_valid_reg || out_ready;

    rrcs_engine #(
        .ARRAY_DEPTH (ARRAY_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .left_index    (left_index),
        .right_index   (right_index),
        .key_value     (key_value),
        .element_value (element_value),
        .array_length  (array_length_reg),
        .res_free      (res_free),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            array_length_reg <= LEN_BITS'(1024);
        else if (cfg_we)
            array_length_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_res_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign match_count = out_res_reg.match_count;
    assign status      = out_res_reg.status;

`ifndef SYNTHESIS
    a_err_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> match_count == '0)
        else $error("error result with nonzero match_count");

    a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && res_valid))
        else $error("input taken while engine result pending");

    a_load_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operation == OP_LOAD || operation == OP_NONE)
        && res_free |=> res_valid)
        else $error("single-cycle operation result not ready");
`endif

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for range_rotate_count_store_top (load, range rotate, range count).
// Keeps a shadow copy of the element store and length register to predict each result.
// Depends on rrcs_pkg and range_rotate_count_store_top.
`timescale 1ns / 1ps

module tb;
    import rrcs_pkg::*;

    localparam int DEPTH       = DEF_ARRAY_DEPTH;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_STALL  = 400;

    typedef struct {
        op_t                   operation;
        logic [IDX_BITS-1:0]   left_index;
        logic [IDX_BITS-1:0]   right_index;
        logic [KEY_BITS-1:0]   key_value;
        logic [KEY_BITS-1:0]   element_value;
    } store_op_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [LEN_BITS-1:0]   cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            operation = '0;
    logic [IDX_BITS-1:0]   left_index = '0;
    logic [IDX_BITS-1:0]   right_index = '0;
    logic [KEY_BITS-1:0]   key_value = '0;
    logic [KEY_BITS-1:0]   element_value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [COUNT_BITS-1:0] match_count;
    logic                  status;

    store_op_t pending_ops[$];
    res_t      expected_results[$];
    store_op_t cur_op;

    logic [KEY_BITS-1:0]   shadow_store[DEPTH];
    logic [LEN_BITS-1:0]   shadow_len = LEN_BITS'(DEPTH);
    bit                    loaded_map[DEPTH];
    int                    gen_eff = DEPTH;

    int  err_cnt = 0;
    int  result_cnt = 0;
    int  cycle_cnt = 0;
    int  in_wait = 0;
    int  out_wait = 0;
    int  stall_left = 0;
    bit  stall_req = 1'b0;
    bit  stall_ack = 1'b0;
    bit  in_idle_on = 1'b1;
    bit  out_idle_on = 1'b1;

    range_rotate_count_store_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .left_index    (left_index),
        .right_index   (right_index),
        .key_value     (key_value),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .match_count   (match_count),
        .status        (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic res_t apply_store_op(input store_op_t op);
        res_t        r;
        int unsigned lo, hi, eff, i;
        logic [KEY_BITS-1:0] last;
        r = '0;
        eff = (shadow_len > DEPTH) ? DEPTH : shadow_len;
        lo = op.left_index;
        hi = op.right_index;
        case (op.operation) inside
            OP_LOAD:
            begin
                if (lo >= eff)
                    r.status = 1'b1;
                else
                    shadow_store[lo] = op.element_value;
            end
            OP_ROTATE, OP_COUNT:
            begin
                if (lo > hi)
                begin
                    i = lo;
                    lo = hi;
                    hi = i;
                end
                if (hi >= eff)
                    r.status = 1'b1;
                else if (op.operation == OP_ROTATE)
                begin
                    last = shadow_store[hi];
                    for (i = hi; i > lo; i--)
                        shadow_store[i] = shadow_store[i - 1];
                    shadow_store[lo] = last;
                end
                else
                begin
                    for (i = lo; i <= hi; i++)
                        if (shadow_store[i] == op.key_value)
                            r.match_count++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int draw_in_wait();
        return in_idle_on ? $urandom_range(0, 14) : 0;
    endfunction

    function automatic int draw_out_wait();
        return out_idle_on ? $urandom_range(0, 14) : 0;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.insert(expected_results.size(), apply_store_op(cur_op));
                in_wait = draw_in_wait();
            end
            if (!in_valid || in_ready)
            begin
                if (in_wait > 0)
                begin
                    in_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() != 0)
                begin
                    cur_op = pending_ops.pop_front();
                    operation     <= cur_op.operation;
                    left_index    <= cur_op.left_index;
                    right_index   <= cur_op.right_index;
                    key_value     <= cur_op.key_value;
                    element_value <= cur_op.element_value;
                    in_valid      <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            stall_ack <= 1'b0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (stall_req != stall_ack)
        begin
            stall_left <= LONG_STALL;
            stall_ack <= stall_req;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_cnt++;
                if (expected_results.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("result %0d with none pending: count=%0d status=%0d",
                                 result_cnt, match_count, status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (match_count !== want.match_count || status !== want.status)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("result %0d: exp count=%0d status=%0d got %0d %0d",
                                     result_cnt, want.match_count, want.status,
                                     match_count, status);
                    end
                end
                out_wait = draw_out_wait();
            end
            if (stall_left != 0)
                out_ready <= 1'b0;
            else if (out_wait > 0)
            begin
                out_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic logic [KEY_BITS-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return KEY_BITS'($urandom_range(0, 3));
        return KEY_BITS'($urandom);
    endfunction

    task automatic queue_op(input op_t op, input int lo, input int hi,
                            input logic [KEY_BITS-1:0] key, input logic [KEY_BITS-1:0] val);
        store_op_t s;
        s.operation     = op;
        s.left_index    = IDX_BITS'(lo);
        s.right_index   = IDX_BITS'(hi);
        s.key_value     = key;
        s.element_value = val;
        if (op == OP_LOAD && lo < gen_eff)
            loaded_map[lo] = 1'b1;
        pending_ops.insert(pending_ops.size(), s);
    endtask

    // ranges stay in [base, base+span-1] except probes; unloaded ranges become loads
    task automatic gen_random(input int n, input int base, input int span, input int rmax);
        int  k, pick, lo, hi, j, hole;
        op_t op;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            lo = base + $urandom_range(0, span - 1);
            if (pick < 5)
                queue_op(OP_NONE, $urandom_range(0, DEPTH - 1), $urandom_range(0, DEPTH - 1),
                         pick_value(), pick_value());
            else if (pick < 10)
            begin
                lo = $urandom_range(0, DEPTH - 1);
                hi = $urandom_range(0, DEPTH - 1);
                op = pick[0] ? OP_ROTATE : OP_COUNT;
                if (lo >= gen_eff || hi >= gen_eff)
                    queue_op(op, lo, hi, pick_value(), pick_value());
                else
                    queue_op(OP_LOAD, lo, hi, pick_value(), pick_value());
            end
            else if (pick < 38)
                queue_op(OP_LOAD, lo, $urandom_range(0, DEPTH - 1), pick_value(), pick_value());
            else
            begin
                hi = lo + $urandom_range(0, rmax - 1);
                if (hi > base + span - 1)
                    hi = base + span - 1;
                hole = -1;
                if (hi < gen_eff)
                    for (j = hi; j >= lo; j--)
                        if (!loaded_map[j])
                            hole = j;
                if (hole >= 0)
                    queue_op(OP_LOAD, hole, lo, pick_value(), pick_value());
                else
                begin
                    op = (pick < 69) ? OP_ROTATE : OP_COUNT;
                    if (pick[0])
                        queue_op(op, hi, lo, pick_value(), pick_value());
                    else
                        queue_op(op, lo, hi, pick_value(), pick_value());
                end
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_length(input logic [LEN_BITS-1:0] len);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_len = len;
        gen_eff = (len > DEPTH) ? DEPTH : len;
        @(negedge clk);
    endtask

    initial
    begin
        int j;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset length, directed
        queue_op(OP_LOAD, 0, 0, 16'h0000, 16'hFFFF);
        queue_op(OP_LOAD, 1, 1023, 16'hFFFF, 16'h0000);
        queue_op(OP_LOAD, 2, 0, 16'h0000, 16'hFFFF);
        queue_op(OP_LOAD, 3, 0, 16'h0000, 16'h1234);
        queue_op(OP_LOAD, 1023, 0, 16'h0000, 16'h8001);
        queue_op(OP_LOAD, 1022, 0, 16'h0000, 16'hFFFF);
        queue_op(OP_COUNT, 0, 3, 16'hFFFF, 16'h0000);
        queue_op(OP_COUNT, 3, 0, 16'h0000, 16'hFFFF);
        queue_op(OP_ROTATE, 0, 3, 16'h0000, 16'h0000);
        queue_op(OP_ROTATE, 3, 1, 16'hFFFF, 16'hFFFF);
        queue_op(OP_ROTATE, 2, 2, 16'h0000, 16'h0000);
        queue_op(OP_COUNT, 1022, 1023, 16'hFFFF, 16'h0000);
        queue_op(OP_ROTATE, 1022, 1023, 16'h0000, 16'h0000);
        queue_op(OP_NONE, 1023, 1023, 16'hFFFF, 16'hFFFF);
        queue_op(OP_COUNT, 0, 0, 16'h1234, 16'h0000);
        gen_random(140, 0, 48, 16);

        // short array: bounds errors
        out_idle_on = 1'b0;
        write_length(11'd4);
        queue_op(OP_LOAD, 4, 0, 16'h0000, 16'h5555);
        queue_op(OP_LOAD, 1023, 0, 16'h0000, 16'h0000);
        queue_op(OP_COUNT, 4, 0, 16'hFFFF, 16'h0000);
        queue_op(OP_ROTATE, 0, 3, 16'h0000, 16'h0000);
        queue_op(OP_COUNT, 3, 0, 16'hFFFF, 16'h0000);
        gen_random(40, 0, 6, 6);

        // zero length
        out_idle_on = 1'b1;
        write_length(11'd0);
        queue_op(OP_LOAD, 0, 0, 16'h0000, 16'h1111);
        queue_op(OP_COUNT, 0, 0, 16'h0000, 16'h0000);
        queue_op(OP_ROTATE, 0, 0, 16'h0000, 16'h0000);
        queue_op(OP_NONE, 0, 0, 16'h0000, 16'h0000);
        gen_random(10, 0, 8, 4);

        // single element
        write_length(11'd1);
        queue_op(OP_COUNT, 0, 0, 16'hFFFF, 16'h0000);
        queue_op(OP_ROTATE, 0, 0, 16'h0000, 16'h0000);
        queue_op(OP_LOAD, 1, 0, 16'h0000, 16'h2222);
        queue_op(OP_COUNT, 0, 1, 16'h0000, 16'h0000);
        gen_random(20, 0, 2, 2);

        // oversized length, top of the array, receiver held off
        write_length(11'd2047);
        in_idle_on = 1'b0;
        stall_req = ~stall_req;
        queue_op(OP_COUNT, 1023, 1022, 16'hFFFF, 16'h0000);
        gen_random(120, 960, 64, 24);

        // 64 elements, ranges up to the whole array
        write_length(11'd64);
        in_idle_on = 1'b1;
        gen_random(120, 0, 64, 64);
        for (j = 0; j < 64; j++)
            if (!loaded_map[j])
                queue_op(OP_LOAD, j, 0, 16'h0000, pick_value());
        queue_op(OP_COUNT, 0, 63, pick_value(), 16'h0000);
        queue_op(OP_ROTATE, 63, 0, 16'h0000, 16'h0000);
        queue_op(OP_COUNT, 63, 0, pick_value(), 16'h0000);

        // back to full length, no idling
        write_length(11'd1024);
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        gen_random(100, 480, 48, 16);

        wait_idle();
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rrcs_pkg.sv
design/rrcs_engine.sv
design/range_rotate_count_store_top.sv
sim/tb.sv
